// ===== src/srank_pkg.sv =====
// Shared types and constants for the stable rank assigner.
package srank_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int VALUE_W   = 32;
    localparam int RANK_W    = 6;

    // Sequencer states
    typedef enum logic [2:0] {
        S_LOAD,
        S_FETCH,
        S_PIVOT,
        S_SCAN,
        S_DRAIN,
        S_OUT
    } t_state;

    // Controls from the sequencer to the compare unit
    typedef struct packed {
        logic load_pivot;
        logic issue;
    } t_cmp_ctl;

endpackage

// ===== src/srank_store.sv =====
// Value store: one write port, one registered read port.
module srank_store
    import srank_pkg::*;
#(
    parameter  int DEPTH = DEPTH_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic signed [VALUE_W-1:0] i_wr_data,
    input  logic [AW-1:0]             i_rd_addr,
    output logic signed [VALUE_W-1:0] o_rd_data
);

    logic signed [VALUE_W-1:0] r_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/srank_cmp.sv =====
// Shared compare unit: one stored word against the pivot per cycle, counting hits.
module srank_cmp
    import srank_pkg::*;
#(
    parameter  int DEPTH = DEPTH_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmp_ctl                  i_ctl,
    input  logic [AW-1:0]             i_idx,
    input  logic [AW-1:0]             i_pivot_idx,
    input  logic signed [VALUE_W-1:0] i_rd_data,
    output logic [AW-1:0]             o_rank
);

    logic                      r_cv;
    logic [AW-1:0]             r_cj;
    logic signed [VALUE_W-1:0] r_pivot;
    logic [AW-1:0]             r_rank;
    logic                      n_hit;

    // read data arrives in the cycle after its address is issued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= 1'b0;
        end else begin
            r_cv <= i_ctl.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cj <= i_idx;
    end

    // smaller, or equal and earlier in the set
    always_comb begin
        n_hit = (i_rd_data < r_pivot) ||
                ((i_rd_data == r_pivot) && (r_cj < i_pivot_idx));
    end

    // pivot capture and rank count
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_pivot) begin
            r_pivot <= i_rd_data;
            r_rank  <= '0;
        end else if (r_cv && n_hit) begin
            r_rank  <= r_rank + AW'(1);
        end
    end

    assign o_rank = r_rank;

endmodule

// ===== src/srank_seq.sv =====
// Sequencer: loads the set, then walks pivot and scan indices for each result.
module srank_seq
    import srank_pkg::*;
#(
    parameter  int DEPTH = DEPTH_DEF,
    localparam int AW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_last,
    output logic          o_ready,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [AW-1:0] o_rd_addr,
    output t_cmp_ctl      o_cmp_ctl,
    output logic [AW-1:0] o_pivot_idx,
    output logic          o_valid,
    input  logic          i_ready,
    output logic          o_last_rank,
    output logic          o_dropped
);

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [AW-1:0] r_last_idx;
    logic [AW-1:0] r_i;
    logic [AW-1:0] r_j;
    logic          n_acc;
    logic          n_full;
    logic          n_last_i;

    assign n_acc    = (r_state == S_LOAD) && i_valid;
    assign n_full   = (r_count == CW'(DEPTH));
    assign n_last_i = (r_i == r_last_idx);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (i_valid && i_last) n_state = S_FETCH;
            end
            S_FETCH: n_state = S_PIVOT;
            S_PIVOT: begin
                n_state = (r_last_idx == '0) ? S_DRAIN : S_SCAN;
            end
            S_SCAN: begin
                if (r_j == r_last_idx) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_OUT;
            S_OUT: begin
                if (i_ready) n_state = n_last_i ? S_LOAD : S_FETCH;
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // outputs
    always_comb begin
        o_ready              = 1'b0;
        o_valid              = 1'b0;
        o_rd_addr            = r_i;
        o_cmp_ctl.load_pivot = 1'b0;
        o_cmp_ctl.issue      = 1'b0;
        unique case (r_state)
            S_LOAD:  o_ready = 1'b1;
            S_FETCH: o_rd_addr = r_i;
            S_PIVOT: begin
                o_rd_addr            = '0;
                o_cmp_ctl.load_pivot = 1'b1;
                o_cmp_ctl.issue      = 1'b1;
            end
            S_SCAN: begin
                o_rd_addr       = r_j;
                o_cmp_ctl.issue = 1'b1;
            end
            S_DRAIN: o_rd_addr = r_i;
            S_OUT:   o_valid = 1'b1;
            default: o_ready = 1'b0;
        endcase
    end

    assign o_wr_en     = n_acc && !n_full;
    assign o_wr_addr   = r_count[AW-1:0];
    assign o_pivot_idx = r_i;
    assign o_last_rank = n_last_i;
    assign o_dropped   = r_ovf;

    // fill count and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (n_acc) begin
            if (n_full) begin
                r_ovf <= 1'b1;
            end else begin
                r_count <= r_count + CW'(1);
            end
        end else if ((r_state == S_OUT) && i_ready && n_last_i) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end
    end

    // pivot and scan indices
    always_ff @(posedge i_clk) begin
        if (n_acc && i_last) begin
            r_last_idx <= n_full ? AW'(DEPTH - 1) : r_count[AW-1:0];
            r_i        <= '0;
        end else if ((r_state == S_OUT) && i_ready && !n_last_i) begin
            r_i <= r_i + AW'(1);
        end
        if (r_state == S_PIVOT) begin
            r_j <= AW'(1);
        end else if (r_state == S_SCAN) begin
            r_j <= r_j + AW'(1);
        end
    end

endmodule

// ===== src/stable_rank_assigner.sv =====
// Top level of the stable rank assigner.
// Words are loaded one per cycle while o_ready is high; the word with i_last
// ends the set, after which o_ready stays low until every rank is delivered.
// For each rank of n stored words the sequencer reads the pivot, passes the
// shared comparator over all n words through the single read port of the
// value store, drains the last compare, then holds the rank until accepted.
// Ranks come out in arrival order; words beyond DEPTH are discarded and flag
// o_dropped on every rank of that set. The store needs no clearing pass.
module stable_rank_assigner
    import srank_pkg::*;
#(
    parameter  int DEPTH = DEPTH_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_last,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [RANK_W-1:0]         o_rank,
    output logic                      o_last_rank,
    output logic                      o_dropped
);

    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [AW-1:0]             rd_addr;
    logic signed [VALUE_W-1:0] rd_data;
    t_cmp_ctl                  cmp_ctl;
    logic [AW-1:0]             pivot_idx;
    logic [AW-1:0]             rank;

    // sequencer
    srank_seq #(.DEPTH(DEPTH)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_last      (i_last),
        .o_ready     (o_ready),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_rd_addr   (rd_addr),
        .o_cmp_ctl   (cmp_ctl),
        .o_pivot_idx (pivot_idx),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_last_rank (o_last_rank),
        .o_dropped   (o_dropped)
    );

    // value store
    srank_store #(.DEPTH(DEPTH)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_value),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // shared comparator and rank counter
    srank_cmp #(.DEPTH(DEPTH)) u_cmp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (cmp_ctl),
        .i_idx       (rd_addr),
        .i_pivot_idx (pivot_idx),
        .i_rd_data   (rd_data),
        .o_rank      (rank)
    );

    assign o_rank = RANK_W'(rank);

endmodule

// ===== tb/tb_stable_rank_assigner.sv =====
// Self-checking testbench for the stable rank assigner.
`timescale 1ns / 1ps

module tb_stable_rank_assigner;
    import srank_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
    localparam logic signed [VALUE_W-1:0] INT_MIN_V = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] INT_MAX_V = 32'sh7FFF_FFFF;

    typedef struct {
        logic [RANK_W-1:0] rank;
        logic              last_rank;
        logic              dropped;
    } t_rank_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      i_last = 1'b0;
    logic                      i_ready = 1'b0;
    logic                      o_ready;
    logic                      o_valid;
    logic [RANK_W-1:0]         o_rank;
    logic                      o_last_rank;
    logic                      o_dropped;

    // Predictor state: words of the open set and its overflow flag
    logic signed [VALUE_W-1:0] set_words[$];
    logic                      set_overflow = 1'b0;
    t_rank_result              rank_expect_q[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_request = 0;
    int rx_hold_left = 0;
    int stall_cycles = 0;
    int error_count = 0;
    int words_sent = 0;
    int sets_sent = 0;
    int dropped_sets = 0;
    int ranks_checked = 0;

    stable_rank_assigner #(.DEPTH(DEPTH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rank      (o_rank),
        .o_last_rank (o_last_rank),
        .o_dropped   (o_dropped)
    );

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Stable ascending rank of each stored word, queued in arrival order
    function automatic void predict_word(input logic signed [VALUE_W-1:0] value,
                                         input logic last);
        int n;
        int r;
        t_rank_result res;
        if (set_words.size() < DEPTH) set_words.push_back(value);
        else set_overflow = 1'b1;
        if (!last) return;
        n = set_words.size();
        for (int i = 0; i < n; i++) begin
            r = 0;
            // signed compare gives the same order as the offset-binary key
            for (int j = 0; j < n; j++) begin
                if (set_words[j] < set_words[i] || (set_words[j] == set_words[i] && j < i))
                    r++;
            end
            res.rank      = r[RANK_W-1:0];
            res.last_rank = (i == n - 1);
            res.dropped   = set_overflow;
            rank_expect_q.push_back(res);
        end
        sets_sent++;
        if (set_overflow) dropped_sets++;
        set_words.delete();
        set_overflow = 1'b0;
    endfunction

    function automatic logic signed [VALUE_W-1:0] rand_value();
        int mode;
        mode = $urandom_range(9);
        if (mode < 5) return $urandom;
        if (mode < 8) return $signed($urandom_range(6)) - 3;   // dense range, many ties
        case ($urandom_range(3))
            0: return INT_MIN_V;
            1: return INT_MAX_V;
            2: return -1;
            default: return 0;
        endcase
    endfunction

    // Offer one word, idling first at random; valid stays high after acceptance
    task automatic send_word(input logic signed [VALUE_W-1:0] value, input logic last);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_valid <= 1'b1;
        i_value <= value;
        i_last  <= last;
        do @(posedge i_clk); while (!o_ready);
        predict_word(value, last);
        words_sent++;
    endtask

    task automatic idle_sender();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_set(input logic signed [VALUE_W-1:0] vals[$]);
        foreach (vals[k]) send_word(vals[k], k == vals.size() - 1);
    endtask

    task automatic send_random_set(input int len);
        for (int k = 0; k < len; k++) send_word(rand_value(), k == len - 1);
    endtask

    task automatic wait_ranks_drained();
        while (rank_expect_q.size() != 0) @(posedge i_clk);
    endtask

    // Extremes, ties, reverse order and single-word sets
    task automatic test_directed();
        send_set('{INT_MIN_V});
        send_set('{INT_MAX_V});
        send_set('{-32'sd1});
        send_set('{32'sd0});
        send_set('{INT_MAX_V, -32'sd1, INT_MIN_V, 32'sd0, -32'sd1, INT_MAX_V, INT_MIN_V,
                   32'sd1});
        send_set('{32'sd7, 32'sd7, 32'sd7});
        send_set('{32'sd3, 32'sd2, 32'sd1, -32'sd4});
        idle_sender();
    endtask

    // Full store, overflow ending on a dropped word, last word the first one dropped
    task automatic test_capacity();
        send_random_set(DEPTH);
        send_random_set(DEPTH + 3);
        send_random_set(DEPTH + 1);
        idle_sender();
    endtask

    // Well-formed sets of random length, mostly short
    task automatic test_random_traffic(input int n_words);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < n_words) begin
            pick = $urandom_range(99);
            if (pick < 70)      len = $urandom_range(8, 1);
            else if (pick < 90) len = $urandom_range(24, 9);
            else if (pick < 96) len = $urandom_range(DEPTH, 25);
            else                len = $urandom_range(DEPTH + 6, DEPTH + 1);
            send_random_set(len);
            sent += len;
        end
        idle_sender();
    endtask

    // Receiver holds off while the sender keeps offering the next set
    task automatic test_backpressure();
        rx_hold_request = 300;
        send_random_set(12);
        send_random_set(8);
        idle_sender();
    endtask

    // Sender pauses until every rank is back before starting again
    task automatic test_drain_pause();
        send_random_set(10);
        idle_sender();
        wait_ranks_drained();
        send_random_set(5);
        idle_sender();
    endtask

    // Receiver: check accepted ranks, then decide next ready
    always @(posedge i_clk) begin
        t_rank_result exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            ranks_checked++;
            if (rank_expect_q.size() == 0) begin
                $display("%0t: unexpected rank word: rank=%0d last=%0b dropped=%0b",
                         $time, o_rank, o_last_rank, o_dropped);
                error_count++;
            end else begin
                exp_res = rank_expect_q.pop_front();
                if (o_rank !== exp_res.rank) begin
                    $display("%0t: rank mismatch: expected %0d, got %0d",
                             $time, exp_res.rank, o_rank);
                    error_count++;
                end
                if (o_last_rank !== exp_res.last_rank) begin
                    $display("%0t: last_rank mismatch: expected %0b, got %0b",
                             $time, exp_res.last_rank, o_last_rank);
                    error_count++;
                end
                if (o_dropped !== exp_res.dropped) begin
                    $display("%0t: dropped mismatch: expected %0b, got %0b",
                             $time, exp_res.dropped, o_dropped);
                    error_count++;
                end
            end
        end
        if (rx_hold_request > 0) begin
            rx_hold_left = rx_hold_request;
            rx_hold_request = 0;
        end
        if (rx_hold_left > 0) begin
            i_ready <= 1'b0;
            rx_hold_left--;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: timeout, %0d ranks still awaited", $time, rank_expect_q.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 12;
        rx_idle_pct = 72;
        test_directed();
        test_capacity();
        test_random_traffic(20);

        tx_idle_pct = 72;
        rx_idle_pct = 12;
        test_random_traffic(20);
        test_backpressure();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_drain_pause();
        test_random_traffic(20);

        wait_ranks_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (rank_expect_q.size() != 0) begin
            $display("%0t: %0d ranks never arrived", $time, rank_expect_q.size());
            error_count++;
        end

        $display("Covered %0d words in %0d sets (%0d with dropped words), %0d ranks checked,",
                 words_sent, sets_sent, dropped_sets, ranks_checked);
        $display("under light, heavy and no idling on each side plus a long receiver hold.");
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
